[hdl/rwlt_pkg.sv]
package rwlt_pkg;

  localparam int LockObjectsDef   = 256;
  localparam int RegistrySlotsDef = 64;
  localparam int HolderBitsDef    = 16;

  localparam int ModeW   = 2;
  localparam int LockIdW = 8;
  localparam int ReqW    = 32;
  localparam int StatusW = 2;
  localparam int LtypeW  = 2;
  localparam int HcountW = 16;
  localparam int EntW    = 7;

  typedef enum logic [1:0] {
    OP_ACQ_SHARED = 2'd0,
    OP_ACQ_EXCL   = 2'd1,
    OP_RELEASE    = 2'd2,
    OP_QUERY      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    LM_NONE   = 2'd0,
    LM_SHARED = 2'd1,
    LM_EXCL   = 2'd2,
    LM_UNUSED = 2'd3
  } lmode_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_WOULD_BLOCK = 2'd1,
    ST_MUST_WAIT   = 2'd2,
    ST_OVERFLOW    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_SCAN,
    S_OUT
  } fsm_e;

  typedef struct packed {
    logic            add;
    logic            rem;
    logic            zero_any;
    logic [31:0]     req;
  } reg_cmd_t;

endpackage

[hdl/rwlt_if.sv]
interface rwlt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] lock_id;
  logic [31:0] requester_id;
  logic       no_wait;
  modport source (output valid, mode, lock_id, requester_id, no_wait, input ready);
  modport sink   (input valid, mode, lock_id, requester_id, no_wait, output ready);
endinterface

interface rwlt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  lock_mode;
  logic [15:0] holder_count;
  logic [31:0] owner_id;
  logic        wake_waiters;
  logic [6:0]  registry_entries;
  modport source (output valid, status, lock_mode, holder_count, owner_id, wake_waiters,
                  registry_entries, input ready);
  modport sink   (input valid, status, lock_mode, holder_count, owner_id, wake_waiters,
                  registry_entries, output ready);
endinterface

[hdl/rwlt_ram.sv]
module rwlt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[hdl/rwlt_slot_cell.sv]
// One registry slot. A token rides the chain: add token claims the first
// free slot, remove token clears the first match. Passes token on otherwise.
module rwlt_slot_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clr_i,
  input  rwlt_pkg::reg_cmd_t cmd_i,
  input  logic [15:0]        lock_i,
  input  logic               tok_i,
  output logic               tok_o,
  output logic               took_o
);
  import rwlt_pkg::*;
  logic        valid_q;
  logic [15:0] lock_q;
  logic [31:0] req_q;
  logic        hit_add, hit_rem;

  assign hit_add = tok_i && cmd_i.add && !valid_q;
  assign hit_rem = tok_i && cmd_i.rem && valid_q && lock_q == lock_i &&
                   (cmd_i.zero_any || req_q == cmd_i.req);
  assign took_o  = hit_add || hit_rem;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_o   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      tok_o <= clr_i ? 1'b0 : (tok_i && !took_o);
      if (hit_add) valid_q <= 1'b1;
      if (hit_rem) valid_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (hit_add) begin
      lock_q <= lock_i;
      req_q  <= cmd_i.req;
    end
  end
endmodule

[hdl/reader_writer_lock_table.sv]
// Reader/writer lock table with a holder registry.
// Input channel (in_if): one request per transaction: mode, lock_id,
// requester_id, no_wait. Output channel (out_if): one result transaction per
// request: status, lock_mode, holder_count, owner_id, wake_waiters,
// registry_entries.
// Lock state (mode, count, owner) lives in one RAM read-modify-written per
// request. The registry is a chain of slot cells; an add or remove token
// walks it one cell per cycle, so the first free / first matching slot wins.
// Sequence: the request is registered in S_IDLE, the lock entry is read in
// S_READ, evaluated and written back in S_EXEC, and the result is offered in
// S_OUT. A request that touches the registry first runs one pass (add, or
// remove) in S_SCAN; an owner downgrade or re-take runs a remove pass then an add pass.
// Throughput: one request at a time; a new request is taken in the cycle
// after the result transaction.
// The result register holds until out_if.ready; a stalled receiver stalls
// the input.
// Reset: a clearing pass writes every lock entry free; in_if.ready stays
// low meanwhile. Registry slots reset empty at once.
module reader_writer_lock_table #(
  parameter int LOCK_OBJECTS   = rwlt_pkg::LockObjectsDef,
  parameter int REGISTRY_SLOTS = rwlt_pkg::RegistrySlotsDef,
  parameter int HOLDER_BITS    = rwlt_pkg::HolderBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rwlt_in_if.sink    in_if,
  rwlt_out_if.source out_if
);
  import rwlt_pkg::*;
  localparam int AW = (LOCK_OBJECTS > 1) ? $clog2(LOCK_OBJECTS) : 1;
  localparam int EW = 2 + HOLDER_BITS + 32;
  localparam int CW = $clog2(REGISTRY_SLOTS + 2);
  localparam logic [HOLDER_BITS-1:0] HMax = '1;

  fsm_e state_q, state_d;
  logic [AW:0]  clr_cnt_q;
  logic         clearing;
  logic [1:0]   op_q;
  logic [AW-1:0] lk_q;
  logic [31:0]  req_q;
  logic         nw_q;
  logic [EW-1:0] rd, wd;
  logic         we;
  logic [AW-1:0] waddr;
  logic [1:0]   m;
  logic [HOLDER_BITS-1:0] h;
  logic [31:0]  own;
  logic         is_owner;
  logic [1:0]   nm; logic [HOLDER_BITS-1:0] nh; logic [31:0] no;
  logic [1:0]   st; logic wk; logic do_add, do_rem, chg;
  logic         add_q, rem_q;
  logic [CW-1:0] scan_q;
  logic [6:0]   used_q;
  logic [REGISTRY_SLOTS:0] tok;
  logic [REGISTRY_SLOTS-1:0] took;
  logic         tok_start;
  reg_cmd_t     cmd;
  logic [15:0]  lk16;
  logic [1:0] st_q, lt_q; logic [15:0] hc_q; logic [31:0] ow_q; logic wk_q;
  logic [AW-1:0] lk_wrap [256];

  assign clearing = !clr_cnt_q[AW];
  assign in_if.ready = state_q == S_IDLE && !clearing;
  wire lk_take = in_if.valid && in_if.ready;

  // lock id wrap as a constant table over all 8-bit ids
  for (genvar j = 0; j < 256; j++) begin : g_wrap
    assign lk_wrap[j] = AW'(j % LOCK_OBJECTS);
  end

  rwlt_ram #(.Width(EW), .Depth(1 << AW)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wd),
    .raddr_i(lk_q), .rdata_o(rd));

  assign m   = rd[EW-1 -: 2];
  assign h   = rd[32 +: HOLDER_BITS];
  assign own = rd[31:0];
  assign is_owner = m == LM_EXCL && own == req_q;

  always_comb begin
    nm = m; nh = h; no = own; st = ST_OK; wk = 1'b0; do_add = 1'b0; do_rem = 1'b0;
    case (op_e'(op_q))
      OP_ACQ_SHARED: begin
        if (m == LM_EXCL && !is_owner) st = nw_q ? ST_WOULD_BLOCK : ST_MUST_WAIT;
        else if (m == LM_SHARED) begin
          if (h == HMax) st = ST_OVERFLOW;
          else begin nh = h + 1'b1; do_add = 1'b1; end
        end else begin
          do_rem = is_owner; nm = LM_SHARED; nh = HOLDER_BITS'(1); no = '0; do_add = 1'b1;
        end
      end
      OP_ACQ_EXCL: begin
        if (m == LM_SHARED || (m == LM_EXCL && !is_owner))
          st = nw_q ? ST_WOULD_BLOCK : ST_MUST_WAIT;
        else begin
          do_rem = is_owner; nm = LM_EXCL; nh = HOLDER_BITS'(1); no = req_q; do_add = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (is_owner) begin
          nm = LM_NONE; nh = '0; no = '0; do_rem = 1'b1; wk = 1'b1;
        end else if (m == LM_SHARED && h != '0) begin
          nh = h - 1'b1; do_rem = 1'b1;
          if (h == HOLDER_BITS'(1)) begin nm = LM_NONE; no = '0; wk = 1'b1; end
        end
      end
      default: ;
    endcase
    chg = (nm != m) || (nh != h) || (no != own);
  end

  always_comb begin
    we = 1'b0; waddr = lk_q; wd = {nm, nh, no};
    if (clearing) begin we = 1'b1; waddr = clr_cnt_q[AW-1:0]; wd = '0; end
    else if (state_q == S_EXEC) we = chg;
  end

  // registry chain: one token per pass; remove pass then add pass
  assign lk16 = 16'(lk_q);
  assign cmd = '{add: add_q && !rem_q, rem: rem_q, zero_any: req_q == '0, req: req_q};
  assign tok_start = state_q == S_SCAN && scan_q == '0;
  assign tok[0] = tok_start;
  for (genvar i = 0; i < REGISTRY_SLOTS; i++) begin : g_slot
    rwlt_slot_cell u_cell (
      .clk_i, .rst_ni, .clr_i(1'b0), .cmd_i(cmd), .lock_i(lk16),
      .tok_i(tok[i]), .tok_o(tok[i+1]), .took_o(took[i]));
  end
  wire any_took = |took;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (lk_take) state_d = S_READ;
      S_READ: state_d = S_EXEC;
      S_EXEC: state_d = (do_add || do_rem) ? S_SCAN : S_OUT;
      S_SCAN: if (scan_q == CW'(REGISTRY_SLOTS) && !(rem_q && add_q)) state_d = S_OUT;
      S_OUT:  if (out_if.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; clr_cnt_q <= '0; used_q <= '0;
      add_q <= 1'b0; rem_q <= 1'b0; scan_q <= '0;
    end else begin
      state_q <= state_d;
      if (clearing) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (state_q == S_EXEC) begin
        add_q <= do_add; rem_q <= do_rem; scan_q <= '0;
      end
      if (state_q == S_SCAN) begin
        if (any_took) used_q <= rem_q ? used_q - 1'b1 : used_q + 1'b1;
        if (scan_q == CW'(REGISTRY_SLOTS)) begin
          scan_q <= '0;
          rem_q  <= 1'b0;
        end else scan_q <= scan_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (lk_take) begin
      op_q <= in_if.mode; lk_q <= lk_wrap[in_if.lock_id];
      req_q <= in_if.requester_id; nw_q <= in_if.no_wait;
    end
    if (state_q == S_EXEC) begin
      st_q <= st; lt_q <= nm; hc_q <= 16'(nh); ow_q <= no; wk_q <= wk;
    end
  end

  assign out_if.valid            = state_q == S_OUT;
  assign out_if.status           = st_q;
  assign out_if.lock_mode        = lt_q;
  assign out_if.holder_count     = hc_q;
  assign out_if.owner_id         = ow_q;
  assign out_if.wake_waiters     = wk_q;
  assign out_if.registry_entries = used_q;
endmodule

[hdl/rwlt_checker.sv]
module rwlt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready, out_valid, out_ready,
  input logic [1:0] status, lock_mode,
  input logic [15:0] holder_count,
  input logic [31:0] owner_id,
  input logic wake_waiters
);
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(status)) else $error("result dropped");
  a_free_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && lock_mode == 2'd0 |-> holder_count == 16'd0 && owner_id == 32'd0)
    else $error("free lock not empty");
  a_wake_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && wake_waiters |-> lock_mode == 2'd0) else $error("wake on held lock");
endmodule

bind reader_writer_lock_table rwlt_checker u_chk (
  .clk_i, .rst_ni, .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .status(out_if.status),
  .lock_mode(out_if.lock_mode), .holder_count(out_if.holder_count),
  .owner_id(out_if.owner_id), .wake_waiters(out_if.wake_waiters));

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;
  import rwlt_pkg::*;

  logic clk_i;
  logic rst_ni;

  rwlt_in_if  in_if ();
  rwlt_out_if out_if ();

  reader_writer_lock_table u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  typedef struct packed {
    op_e         op;
    logic [7:0]  lk;
    logic [31:0] req;
    logic        nw;
  } lock_req_t;

  typedef struct packed {
    status_e     status;
    lmode_e      ltype;
    logic [15:0] count;
    logic [31:0] owner;
    logic        wake;
    logic [6:0]  entries;
  } lock_rsp_t;

  // Shadow lock table and holder registry.
  lmode_e      sh_mode  [256];
  logic [15:0] sh_count [256];
  logic [31:0] sh_owner [256];
  logic        sh_valid [64];
  logic [7:0]  sh_slk   [64];
  logic [31:0] sh_sreq  [64];
  int          sh_used;

  lock_req_t pending_reqs[$];
  lock_rsp_t expected_rsps[$];
  int        errors;
  bit        stim_done;
  int        stall_hold;

  // Small pool of requester ids so that owners, holders and removals collide.
  logic [31:0] req_pool [8];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void registry_add(logic [7:0] lk, logic [31:0] rq);
    for (int i = 0; i < 64; i++) begin
      if (!sh_valid[i]) begin
        sh_valid[i] = 1'b1;
        sh_slk[i]   = lk;
        sh_sreq[i]  = rq;
        sh_used++;
        return;
      end
    end
  endfunction

  function automatic void registry_remove(logic [7:0] lk, logic [31:0] rq);
    for (int i = 0; i < 64; i++) begin
      if (sh_valid[i] && sh_slk[i] == lk && (rq == 0 || sh_sreq[i] == rq)) begin
        sh_valid[i] = 1'b0;
        if (sh_used > 0) sh_used--;
        return;
      end
    end
  endfunction

  // Applies one request to the shadow state and returns the lock's result.
  function automatic lock_rsp_t apply_lock_request(lock_req_t r);
    lock_rsp_t o;
    logic      owner_hit;
    status_e   busy;
    logic [7:0] k;
    k         = r.lk;
    owner_hit = (sh_mode[k] == LM_EXCL) && (sh_owner[k] == r.req);
    busy      = r.nw ? ST_WOULD_BLOCK : ST_MUST_WAIT;
    o.status  = ST_OK;
    o.wake    = 1'b0;
    case (r.op)
      OP_ACQ_SHARED: begin
        if (sh_mode[k] == LM_EXCL && !owner_hit) o.status = busy;
        else if (sh_mode[k] == LM_SHARED) begin
          if (sh_count[k] == 16'hFFFF) o.status = ST_OVERFLOW;
          else begin
            sh_count[k]++;
            registry_add(k, r.req);
          end
        end else begin
          // free, or owner downgrading
          if (owner_hit) registry_remove(k, r.req);
          sh_mode[k]  = LM_SHARED;
          sh_count[k] = 16'd1;
          sh_owner[k] = '0;
          registry_add(k, r.req);
        end
      end
      OP_ACQ_EXCL: begin
        if (sh_mode[k] == LM_SHARED || (sh_mode[k] == LM_EXCL && !owner_hit))
          o.status = busy;
        else begin
          if (owner_hit) registry_remove(k, r.req);
          sh_mode[k]  = LM_EXCL;
          sh_count[k] = 16'd1;
          sh_owner[k] = r.req;
          registry_add(k, r.req);
        end
      end
      OP_RELEASE: begin
        if (sh_mode[k] == LM_EXCL) begin
          if (owner_hit) begin
            sh_mode[k]  = LM_NONE;
            sh_count[k] = '0;
            sh_owner[k] = '0;
            registry_remove(k, r.req);
            o.wake = 1'b1;
          end
        end else if (sh_mode[k] == LM_SHARED && sh_count[k] != 0) begin
          sh_count[k]--;
          registry_remove(k, r.req);
          if (sh_count[k] == 0) begin
            sh_mode[k]  = LM_NONE;
            sh_owner[k] = '0;
            o.wake = 1'b1;
          end
        end
      end
      default: ;
    endcase
    o.ltype   = sh_mode[k];
    o.count   = sh_count[k];
    o.owner   = sh_owner[k];
    o.entries = sh_used[6:0];
    return o;
  endfunction

  function automatic lock_req_t mk_req(op_e op, logic [7:0] lk, logic [31:0] rq,
                                       logic nw);
    lock_req_t r;
    r.op = op; r.lk = lk; r.req = rq; r.nw = nw;
    return r;
  endfunction

  // Stimulus
  initial begin
    lock_req_t r;
    int        n;
    for (int i = 0; i < 8; i++) req_pool[i] = $urandom;
    req_pool[0] = 32'd0;
    req_pool[1] = 32'hFFFF_FFFF;
    // Directed: extremes, every operation, conflicts, downgrade, re-take.
    pending_reqs.push_back(mk_req(OP_QUERY,      8'd0,   32'd0,        1'b0));
    pending_reqs.push_back(mk_req(OP_RELEASE,    8'd0,   32'd5,        1'b0)); // free
    pending_reqs.push_back(mk_req(OP_ACQ_EXCL,   8'd255, 32'hFFFFFFFF, 1'b0));
    pending_reqs.push_back(mk_req(OP_ACQ_EXCL,   8'd255, 32'd7,        1'b1)); // would block
    pending_reqs.push_back(mk_req(OP_ACQ_SHARED, 8'd255, 32'd7,        1'b0)); // must wait
    pending_reqs.push_back(mk_req(OP_RELEASE,    8'd255, 32'd7,        1'b0)); // non-owner
    pending_reqs.push_back(mk_req(OP_ACQ_EXCL,   8'd255, 32'hFFFFFFFF, 1'b0)); // re-take
    pending_reqs.push_back(mk_req(OP_ACQ_SHARED, 8'd255, 32'hFFFFFFFF, 1'b1)); // downgrade
    pending_reqs.push_back(mk_req(OP_ACQ_SHARED, 8'd255, 32'd9,        1'b0));
    pending_reqs.push_back(mk_req(OP_ACQ_EXCL,   8'd255, 32'd9,        1'b1)); // shared conflict
    pending_reqs.push_back(mk_req(OP_RELEASE,    8'd255, 32'd0,        1'b0)); // zero matches any
    pending_reqs.push_back(mk_req(OP_RELEASE,    8'd255, 32'd1234,     1'b0)); // frees, wake
    pending_reqs.push_back(mk_req(OP_QUERY,      8'd255, 32'hFFFFFFFF, 1'b1));
    pending_reqs.push_back(mk_req(OP_ACQ_EXCL,   8'd0,   32'd0,        1'b0)); // owner id 0
    pending_reqs.push_back(mk_req(OP_RELEASE,    8'd0,   32'd0,        1'b0));
    // Fill the registry past 64 slots so entries are dropped.
    for (int i = 0; i < 70; i++)
      pending_reqs.push_back(mk_req(OP_ACQ_SHARED, 8'd17, $urandom, i[0]));
    for (int i = 0; i < 70; i++)
      pending_reqs.push_back(mk_req(OP_RELEASE, 8'd17, 32'd0, 1'b0));
    // Random: few locks and ids so sequences interact.
    n = 0;
    while (n < 1200) begin
      r.op  = op_e'($urandom_range(0, 3));
      r.lk  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
      r.req = ($urandom_range(0, 9) == 0) ? $urandom : req_pool[$urandom_range(0, 7)];
      r.nw  = 1'($urandom_range(0, 1));
      pending_reqs.push_back(r);
      n++;
    end
    stim_done = 1'b1;
  end

  // Reset
  initial begin
    errors     = 0;
    rst_ni     = 1'b0;
    for (int i = 0; i < 256; i++) begin
      sh_mode[i] = LM_NONE; sh_count[i] = '0; sh_owner[i] = '0;
    end
    for (int i = 0; i < 64; i++) begin
      sh_valid[i] = 1'b0; sh_slk[i] = '0; sh_sreq[i] = '0;
    end
    sh_used = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
  end

  // Driver: bursts and gaps, changes on the falling edge.
  int burst_left, gap_left;
  bit acc_in;
  initial begin
    in_if.valid = 1'b0; in_if.mode = '0; in_if.lock_id = '0;
    in_if.requester_id = '0; in_if.no_wait = 1'b0;
    burst_left = 0; gap_left = 0;
  end

  always @(posedge clk_i) begin
    acc_in <= rst_ni && in_if.valid && in_if.ready;
    if (rst_ni && in_if.valid && in_if.ready) begin
      // accepted transaction: predict it now
      expected_rsps.push_back(apply_lock_request(pending_reqs.pop_front()));
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && !acc_in) begin
        // hold the offered transaction
      end else if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
        end
        burst_left--;
        in_if.valid        <= 1'b1;
        in_if.mode         <= pending_reqs[0].op;
        in_if.lock_id      <= pending_reqs[0].lk;
        in_if.requester_id <= pending_reqs[0].req;
        in_if.no_wait      <= pending_reqs[0].nw;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern, with one long hold-off early on.
  int rx_cyc;
  initial begin
    out_if.ready = 1'b0;
    rx_cyc = 0;
    stall_hold = 0;
  end

  always @(negedge clk_i) begin
    rx_cyc <= rx_cyc + 1;
    if (rx_cyc == 600) stall_hold <= 800;
    else if (stall_hold > 0) stall_hold <= stall_hold - 1;
    if (stall_hold > 0) out_if.ready <= 1'b0;
    else if ((rx_cyc / 300) % 3 == 1) out_if.ready <= 1'b1;  // no-stall stretch
    else out_if.ready <= ($urandom_range(0, 3) != 0);
  end

  // Monitor: compare each result transaction with the oldest prediction.
  always @(posedge clk_i) begin
    lock_rsp_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected result transaction", $realtime);
        errors++;
      end else begin
        e = expected_rsps.pop_front();
        if (out_if.status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $realtime, e.status, out_if.status);
          errors++;
        end
        if (out_if.lock_mode !== e.ltype) begin
          $display("%0t: lock_mode exp %0d got %0d", $realtime, e.ltype, out_if.lock_mode);
          errors++;
        end
        if (out_if.holder_count !== e.count) begin
          $display("%0t: holder_count exp %0d got %0d", $realtime, e.count,
                   out_if.holder_count);
          errors++;
        end
        if (out_if.owner_id !== e.owner) begin
          $display("%0t: owner_id exp %h got %h", $realtime, e.owner, out_if.owner_id);
          errors++;
        end
        if (out_if.wake_waiters !== e.wake) begin
          $display("%0t: wake_waiters exp %0d got %0d", $realtime, e.wake,
                   out_if.wake_waiters);
          errors++;
        end
        if (out_if.registry_entries !== e.entries) begin
          $display("%0t: registry_entries exp %0d got %0d", $realtime, e.entries,
                   out_if.registry_entries);
          errors++;
        end
      end
    end
  end

  // End of run: all accepted, all answered, then drain for the latency.
  initial begin
    wait (stim_done);
    wait (pending_reqs.size() == 0 && !in_if.valid);
    wait (expected_rsps.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_rsps.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // Slowest run: ~1350 items, each with up to two registry passes plus gaps and stalls, well under this.
  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule
